[hdl/scma_pkg.sv]
// ----------------------------------------------------------------------------
// scma_pkg: shared types and constants of the class map argmax unit
// Frame limits, field widths, register indexes and the frame store entry.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int MAX_CLASSES = 256;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int SCORE_W     = 16;
  localparam int LABEL_W     = 8;
  localparam int PLANE_W     = 8;
  localparam int CLASSES_W   = 9;
  localparam int SIZE_W      = 8;
  localparam int PIX_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT = 2'd0,
    REG_FRAME_WIDTH = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_CONF_THRESHOLD = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [LABEL_W-1:0]        cls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/scma_ram.sv]
// ----------------------------------------------------------------------------
// scma_ram: generic simple dual-port RAM
// One write port and one read port, read data registered, read-first.
// ----------------------------------------------------------------------------
module scma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/seg_class_map_argmax_unit.sv]
// ----------------------------------------------------------------------------
// seg_class_map_argmax_unit: per-pixel argmax over class score planes
// Keeps the best score and class of every pixel in a frame store and emits
// thresholded labels while the last plane streams in.
// ----------------------------------------------------------------------------
// The unit takes one score request per clock cycle while the label output is not
// stalled, and delivers at most one label per cycle. A score accepted into the
// read stage goes from there to the output register: the frame store is read at
// the accepting edge, and the compare, write-back and label are settled while
// the score is held in the read stage, with a bypass covering a read and a write
// of the same entry in the same cycle. The frame store is written by plane 0
// before any later plane reads it, so it needs no clearing after reset. Any
// configuration write restarts the frame at pixel 0 of plane 0.
module seg_class_map_argmax_unit
  import scma_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SCORE_W-1:0]   score,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [LABEL_W-1:0]          label,
  output logic [PIX_W-1:0]            pixel_index,
  output logic                        frame_done
);

  // Configuration registers
  logic [CLASSES_W-1:0]      class_count;
  logic [SIZE_W-1:0]         frame_width;
  logic [SIZE_W-1:0]         frame_height;
  logic signed [SCORE_W-1:0] conf_threshold;

  // Raster position
  logic [PLANE_W-1:0] plane_cnt;
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;
  logic [PIX_W-1:0]   pix_cnt;

  // Item waiting for its store read
  logic                      s1_valid;
  logic signed [SCORE_W-1:0] s1_score;
  logic [ADDR_W-1:0]         s1_addr;
  logic [PLANE_W-1:0]        s1_plane;
  logic                      s1_single;
  logic                      s1_first;
  logic                      s1_last_plane;
  logic                      s1_last_pix;
  logic [PIX_W-1:0]          s1_pix;
  logic                      s1_byp;
  entry_t                    s1_byp_ent;

  logic [CLASSES_W-1:0] classes_eff;
  logic [SIZE_W-1:0]    width_eff;
  logic [SIZE_W-1:0]    height_eff;
  logic                 last_col;
  logic                 last_row;
  logic                 last_plane;
  logic                 accept;
  logic [ADDR_W-1:0]    in_addr;

  entry_t               ram_rdata;
  entry_t               old_ent;
  entry_t               wr_ent;
  logic                 greater;
  logic                 ram_we;
  logic                 s1_emit;
  logic                 s1_done;
  logic [LABEL_W-1:0]   label_next;
  logic [LABEL_W-1:0]   best_cls;
  logic signed [SCORE_W-1:0] best_score;

  // Out-of-range sizes are clamped to 1 and to the maxima.
  always_comb begin
    if (class_count == '0) begin
      classes_eff = CLASSES_W'(1);
    end else if (class_count > CLASSES_W'(MAX_CLASSES)) begin
      classes_eff = CLASSES_W'(MAX_CLASSES);
    end else begin
      classes_eff = class_count;
    end
    if (frame_width == '0) begin
      width_eff = SIZE_W'(1);
    end else if (frame_width > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = SIZE_W'(1);
    end else if (frame_height > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  assign last_col   = (SIZE_W'(col_cnt) + SIZE_W'(1)) == width_eff;
  assign last_row   = (SIZE_W'(row_cnt) + SIZE_W'(1)) == height_eff;
  assign last_plane = (CLASSES_W'(plane_cnt) + CLASSES_W'(1)) == classes_eff;
  assign in_addr    = {row_cnt, col_cnt};

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid || s1_done;

  // A write-back in the cycle of the read is not seen by the RAM output.
  assign old_ent = s1_byp ? s1_byp_ent : ram_rdata;
  assign greater = s1_score > old_ent.score;

  always_comb begin
    if (greater) begin
      best_score = s1_score;
      best_cls   = s1_plane;
    end else begin
      best_score = old_ent.score;
      best_cls   = old_ent.cls;
    end
    wr_ent.score = s1_score;
    wr_ent.cls   = s1_first ? '0 : s1_plane;
    if (s1_single) begin
      label_next = (s1_score > conf_threshold) ? LABEL_W'(1) : '0;
    end else begin
      label_next = (best_score < conf_threshold) ? '0 : best_cls;
    end
  end

  assign s1_emit = s1_single || (!s1_first && s1_last_plane);
  assign s1_done = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign ram_we  = s1_done && !s1_single && (s1_first || greater);

  scma_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (wr_ent),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Configuration and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count    <= CLASSES_W'(1);
      frame_width    <= SIZE_W'(MAX_WIDTH);
      frame_height   <= SIZE_W'(MAX_HEIGHT);
      conf_threshold <= 16'sd2048;
      plane_cnt      <= '0;
      col_cnt        <= '0;
      row_cnt        <= '0;
      pix_cnt        <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_CLASS_COUNT:    class_count    <= cfg_data[CLASSES_W-1:0];
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[SIZE_W-1:0];
        REG_CONF_THRESHOLD: conf_threshold <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
      plane_cnt <= '0;
      col_cnt   <= '0;
      row_cnt   <= '0;
      pix_cnt   <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col_cnt <= col_cnt + COL_W'(1);
        pix_cnt <= pix_cnt + PIX_W'(1);
      end else begin
        col_cnt <= '0;
        if (!last_row) begin
          row_cnt <= row_cnt + ROW_W'(1);
          pix_cnt <= pix_cnt + PIX_W'(1);
        end else begin
          row_cnt   <= '0;
          pix_cnt   <= '0;
          plane_cnt <= last_plane ? '0 : plane_cnt + PLANE_W'(1);
        end
      end
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_score      <= score;
      s1_addr       <= in_addr;
      s1_plane      <= plane_cnt;
      s1_single     <= classes_eff == CLASSES_W'(1);
      s1_first      <= plane_cnt == '0;
      s1_last_plane <= last_plane;
      s1_last_pix   <= last_col && last_row;
      s1_pix        <= pix_cnt;
      s1_byp        <= ram_we && (s1_addr == in_addr);
      s1_byp_ent    <= wr_ent;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_emit) begin
      label       <= label_next;
      pixel_index <= s1_pix;
      frame_done  <= s1_last_pix && s1_last_plane;
    end
  end

endmodule
